>>> hdl/lome_pkg.sv
// lome_pkg: shared constants, datapath command codes and the control/status
// structs used between the controller and the datapath of the move engine.
// No dependencies.
package lome_pkg;

   localparam int NODE_W            = 10;
   localparam int OP_W              = 2;
   localparam int NODE_LIMIT        = 1023;
   localparam int MAX_NODES_DEFAULT = 1023;

   localparam logic [NODE_W-1:0] LEN_RESET = 10'd1023;

   localparam logic [OP_W-1:0] OP_INIT = 2'd0;
   localparam logic [OP_W-1:0] OP_MOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ = 2'd2;

   typedef enum logic [3:0] {
      DP_NONE,
      DP_LATCH,
      DP_INIT_START,
      DP_SWEEP,
      DP_READ_ISSUE,
      DP_READ_DONE,
      DP_SET_ERR,
      DP_MOVE_NOOP,
      DP_MOVE_RD,
      DP_MOVE_UNLINK,
      DP_MOVE_LINK1,
      DP_MOVE_LINK2
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] opcode;
      logic            move_bad;
      logic            move_noop;
      logic            sweep_last;
   } dp_status_type;

   // init length forced into 1..max_len
   function automatic logic [NODE_W-1:0] clamp_len(input logic [NODE_W-1:0] len,
                                                   input logic [NODE_W-1:0] max_len);
      logic [NODE_W-1:0] res;
      if (len == '0) begin
         res = 10'd1;
      end else if (len > max_len) begin
         res = max_len;
      end else begin
         res = len;
      end
      return res;
   endfunction

endpackage

>>> hdl/linked_order_move_engine_unit.sv
// linked_order_move_engine_unit: top level of the linked order move engine.
// Depends on lome_pkg, lome_ctrl, lome_dp (and lome_ram through lome_dp).
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_opcode, req_node, req_anchor
//   rsp      out        rsp_valid/rsp_stall  rsp_item, rsp_last, rsp_error
//   csr      in         csr_valid/csr_ready  csr_list_length
//
// one item at a time; read: decode, read wait, done; move: decode, unlink, link1,
// link2, done; rejected move, head to front or unused opcode: decode, done; init:
// decode, clamped length sweep, done; set by one write and one read port per table
// after reset the link tables are built over the clamped reset length
// with req stalled
// a waiting result does not block the next item; the next result waits for rsp
module linked_order_move_engine_unit #(
   parameter int MAX_NODES = lome_pkg::MAX_NODES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [lome_pkg::OP_W-1:0]      req_opcode,
   input  logic [lome_pkg::NODE_W-1:0]    req_node,
   input  logic [lome_pkg::NODE_W-1:0]    req_anchor,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [lome_pkg::NODE_W-1:0]    rsp_item,
   output logic                           rsp_last,
   output logic                           rsp_error,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lome_pkg::NODE_W-1:0]    csr_list_length
);

   lome_pkg::dp_cmd_type    cmd;
   lome_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   lome_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lome_dp #(.MAX_NODES(MAX_NODES)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_list_length (csr_list_length),
      .req_opcode      (req_opcode),
      .req_node        (req_node),
      .req_anchor      (req_anchor),
      .rsp_item        (rsp_item),
      .rsp_last        (rsp_last),
      .rsp_error       (rsp_error),
      .cmd             (cmd),
      .status          (status)
   );

endmodule

>>> hdl/lome_ram.sv
// lome_ram: generic simple dual-port RAM, one write port and one read port,
// registered read data (old data on a same-address read and write).
// No dependencies.
module lome_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/lome_ctrl.sv
// lome_ctrl: sequencer of the move engine; steps the datapath through init
// sweeps, reads and the unlink/relink phases of a move, and owns the handshakes.
// Depends on lome_pkg.
module lome_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  lome_pkg::dp_status_type status,
   output lome_pkg::dp_cmd_type    cmd
);

   typedef enum logic [8:0] {
      S_SWEEP     = 9'b000000001,
      S_IDLE      = 9'b000000010,
      S_DECODE    = 9'b000000100,
      S_READ_WAIT = 9'b000001000,
      S_UNLINK    = 9'b000010000,
      S_LINK1     = 9'b000100000,
      S_LINK2     = 9'b001000000,
      S_DONE      = 9'b010000000,
      S_SPARE     = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      report_ff, report_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      report_in    = report_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd.op       = lome_pkg::DP_NONE;
      cmd.load_rsp = 1'b0;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_SWEEP: begin
            cmd.op = lome_pkg::DP_SWEEP;
            if (status.sweep_last) begin
               // the sweep after reset gives no item
               state_in = report_ff ? S_DONE : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = lome_pkg::DP_LATCH;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            priority if (status.opcode == lome_pkg::OP_INIT) begin
               cmd.op    = lome_pkg::DP_INIT_START;
               report_in = 1'b1;
               state_in  = S_SWEEP;
            end else if (status.opcode == lome_pkg::OP_MOVE) begin
               priority if (status.move_bad) begin
                  cmd.op   = lome_pkg::DP_SET_ERR;
                  state_in = S_DONE;
               end else if (status.move_noop) begin
                  cmd.op   = lome_pkg::DP_MOVE_NOOP;
                  state_in = S_DONE;
               end else begin
                  cmd.op   = lome_pkg::DP_MOVE_RD;
                  state_in = S_UNLINK;
               end
            end else if (status.opcode == lome_pkg::OP_READ) begin
               cmd.op   = lome_pkg::DP_READ_ISSUE;
               state_in = S_READ_WAIT;
            end else begin
               state_in = S_DONE;
            end
         end
         S_READ_WAIT: begin
            cmd.op   = lome_pkg::DP_READ_DONE;
            state_in = S_DONE;
         end
         S_UNLINK: begin
            cmd.op   = lome_pkg::DP_MOVE_UNLINK;
            state_in = S_LINK1;
         end
         S_LINK1: begin
            cmd.op   = lome_pkg::DP_MOVE_LINK1;
            state_in = S_LINK2;
         end
         S_LINK2: begin
            cmd.op   = lome_pkg::DP_MOVE_LINK2;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         report_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         report_ff    <= report_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hdl/lome_dp.sv
// lome_dp: datapath of the move engine; successor and predecessor link RAMs,
// head and cursor registers, the length register and the result registers.
// Depends on lome_pkg and lome_ram.
module lome_dp #(
   parameter int MAX_NODES = lome_pkg::MAX_NODES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   input  logic [lome_pkg::NODE_W-1:0]      csr_list_length,
   input  logic [lome_pkg::OP_W-1:0]        req_opcode,
   input  logic [lome_pkg::NODE_W-1:0]      req_node,
   input  logic [lome_pkg::NODE_W-1:0]      req_anchor,
   output logic [lome_pkg::NODE_W-1:0]      rsp_item,
   output logic                             rsp_last,
   output logic                             rsp_error,
   input  lome_pkg::dp_cmd_type             cmd,
   output lome_pkg::dp_status_type          status
);

   localparam int NW         = lome_pkg::NODE_W;
   localparam int NODES_USED = (MAX_NODES < lome_pkg::NODE_LIMIT) ? MAX_NODES
                                                                   : lome_pkg::NODE_LIMIT;
   localparam int DEPTH      = NODES_USED + 1;
   localparam int AW         = $clog2(DEPTH);
   localparam logic [NW-1:0] NODES_MAX = NW'(NODES_USED);

   logic [NW-1:0]           list_length_ff;
   logic [lome_pkg::OP_W-1:0] opcode_ff;
   logic [NW-1:0]           node_ff, anchor_ff;
   logic [AW-1:0]           active_len_ff, idx_ff, head_ff, cursor_ff;
   logic [AW-1:0]           p_ff, q_ff, succ_ff;
   logic [NW-1:0]           res_item_ff;
   logic                    res_last_ff, res_err_ff;
   logic [NW-1:0]           rsp_item_ff;
   logic                    rsp_last_ff, rsp_error_ff;

   logic          nx_we, pv_we;
   logic [AW-1:0] nx_waddr, nx_wdata, nx_raddr, nx_rdata;
   logic [AW-1:0] pv_waddr, pv_wdata, pv_raddr, pv_rdata;
   logic [AW-1:0] x_addr, y_addr;
   logic          front;

   assign x_addr = node_ff[AW-1:0];
   assign y_addr = anchor_ff[AW-1:0];
   assign front  = (anchor_ff == '0);

   assign status.opcode     = opcode_ff;
   assign status.move_bad   = (node_ff == '0) || (node_ff > NW'(active_len_ff)) ||
                              (anchor_ff > NW'(active_len_ff)) || (node_ff == anchor_ff);
   assign status.move_noop  = front && (node_ff == NW'(head_ff));
   assign status.sweep_last = (idx_ff == active_len_ff);

   lome_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_next_ram (
      .clock (clock),
      .we    (nx_we),
      .waddr (nx_waddr),
      .wdata (nx_wdata),
      .raddr (nx_raddr),
      .rdata (nx_rdata)
   );

   lome_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_prev_ram (
      .clock (clock),
      .we    (pv_we),
      .waddr (pv_waddr),
      .wdata (pv_wdata),
      .raddr (pv_raddr),
      .rdata (pv_rdata)
   );

   // link table ports, in the same write order as the list update needs
   always_comb begin
      nx_we    = 1'b0;
      nx_waddr = '0;
      nx_wdata = '0;
      nx_raddr = '0;
      pv_we    = 1'b0;
      pv_waddr = '0;
      pv_wdata = '0;
      pv_raddr = '0;
      unique case (cmd.op)
         lome_pkg::DP_SWEEP: begin
            nx_we    = 1'b1;
            nx_waddr = idx_ff;
            nx_wdata = (idx_ff < active_len_ff) ? idx_ff + AW'(1) : '0;
            pv_we    = 1'b1;
            pv_waddr = idx_ff;
            pv_wdata = idx_ff - AW'(1);
         end
         lome_pkg::DP_READ_ISSUE: begin
            nx_raddr = cursor_ff;
         end
         lome_pkg::DP_MOVE_RD: begin
            nx_raddr = x_addr;
            pv_raddr = x_addr;
         end
         lome_pkg::DP_MOVE_UNLINK: begin
            // rdata holds successor and predecessor of the moved node
            nx_we    = (pv_rdata != '0);
            nx_waddr = pv_rdata;
            nx_wdata = nx_rdata;
            pv_we    = (nx_rdata != '0);
            pv_waddr = nx_rdata;
            pv_wdata = pv_rdata;
            nx_raddr = y_addr;
         end
         lome_pkg::DP_MOVE_LINK1: begin
            if (front) begin
               nx_we    = 1'b1;
               nx_waddr = x_addr;
               nx_wdata = head_ff;
               pv_we    = 1'b1;
               pv_waddr = x_addr;
               pv_wdata = '0;
            end else begin
               nx_we    = 1'b1;
               nx_waddr = y_addr;
               nx_wdata = x_addr;
               pv_we    = 1'b1;
               pv_waddr = x_addr;
               pv_wdata = y_addr;
            end
         end
         lome_pkg::DP_MOVE_LINK2: begin
            if (front) begin
               pv_we    = (head_ff != '0);
               pv_waddr = head_ff;
               pv_wdata = x_addr;
            end else begin
               nx_we    = 1'b1;
               nx_waddr = x_addr;
               nx_wdata = succ_ff;
               pv_we    = (succ_ff != '0);
               pv_waddr = succ_ff;
               pv_wdata = x_addr;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         list_length_ff <= lome_pkg::LEN_RESET;
         active_len_ff  <= AW'(lome_pkg::clamp_len(lome_pkg::LEN_RESET, NODES_MAX));
         idx_ff         <= AW'(1);
         head_ff        <= AW'(1);
         cursor_ff      <= AW'(1);
      end else begin
         if (csr_valid) begin
            list_length_ff <= csr_list_length;
         end
         unique case (cmd.op)
            lome_pkg::DP_INIT_START: begin
               active_len_ff <= AW'(lome_pkg::clamp_len(list_length_ff, NODES_MAX));
               idx_ff        <= AW'(1);
            end
            lome_pkg::DP_SWEEP: begin
               idx_ff <= idx_ff + AW'(1);
               if (idx_ff == active_len_ff) begin
                  head_ff   <= AW'(1);
                  cursor_ff <= AW'(1);
               end
            end
            lome_pkg::DP_READ_DONE: begin
               if (cursor_ff != '0) begin
                  cursor_ff <= nx_rdata;
               end
            end
            lome_pkg::DP_MOVE_NOOP: begin
               cursor_ff <= head_ff;
            end
            lome_pkg::DP_MOVE_UNLINK: begin
               if (x_addr == head_ff) begin
                  head_ff <= nx_rdata;
               end
            end
            lome_pkg::DP_MOVE_LINK2: begin
               if (front) begin
                  head_ff   <= x_addr;
                  cursor_ff <= x_addr;
               end else begin
                  cursor_ff <= head_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // payload, scratch and response registers
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         lome_pkg::DP_LATCH: begin
            opcode_ff   <= req_opcode;
            node_ff     <= req_node;
            anchor_ff   <= req_anchor;
            res_item_ff <= '0;
            res_last_ff <= 1'b0;
            res_err_ff  <= 1'b0;
         end
         lome_pkg::DP_READ_DONE: begin
            if (cursor_ff != '0) begin
               res_item_ff <= NW'(cursor_ff);
               res_last_ff <= (nx_rdata == '0);
            end
         end
         lome_pkg::DP_SET_ERR: begin
            res_err_ff <= 1'b1;
         end
         lome_pkg::DP_MOVE_UNLINK: begin
            p_ff <= pv_rdata;
            q_ff <= nx_rdata;
         end
         lome_pkg::DP_MOVE_LINK1: begin
            // anchor that was the old predecessor now points at the old successor
            succ_ff <= (y_addr == p_ff) ? q_ff : nx_rdata;
         end
         default: begin
         end
      endcase
      if (cmd.load_rsp) begin
         rsp_item_ff  <= res_item_ff;
         rsp_last_ff  <= res_last_ff;
         rsp_error_ff <= res_err_ff;
      end
   end

   assign rsp_item  = rsp_item_ff;
   assign rsp_last  = rsp_last_ff;
   assign rsp_error = rsp_error_ff;

endmodule
